// ===== sv/iocb_pkg.sv =====
// Package: shared types, codes and constants of the orienting color frame buffer.
package iocb_pkg;

   localparam int MAX_DIM_DEF = 256;
   localparam int DIM_W       = 9;
   localparam int COORD_W     = 8;
   localparam int BYTE_W      = 8;
   localparam int PIX_W       = 3 * BYTE_W;
   localparam int SUM_W       = 10;
   // floor(s / 3) == (s * 683) >> 11 for every s up to 765
   localparam int GREY_RECIP  = 683;
   localparam int GREY_SHIFT  = 11;
   localparam int PROD_W      = 20;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ORIENTATION  = 2'd2,
      CSR_COLOR_OP     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ORIENT_IDENTITY = 3'd0,
      ORIENT_FLIP_H   = 3'd1,
      ORIENT_FLIP_V   = 3'd2,
      ORIENT_ROT_L    = 3'd3,
      ORIENT_ROT_R    = 3'd4
   } orient_type;

   typedef enum logic [2:0] {
      COLOR_NONE    = 3'd0,
      COLOR_GREY    = 3'd1,
      COLOR_CLEAR_2 = 3'd2,
      COLOR_CLEAR_1 = 3'd3,
      COLOR_CLEAR_0 = 3'd4
   } color_type;

   typedef struct packed {
      logic                 func;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [BYTE_W-1:0]    byte_zero;
      logic [BYTE_W-1:0]    byte_one;
      logic [BYTE_W-1:0]    byte_two;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte_zero;
      logic [BYTE_W-1:0]    out_byte_one;
      logic [BYTE_W-1:0]    out_byte_two;
      logic                 status;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]     image_width;
      logic [DIM_W-1:0]     image_height;
      logic [2:0]           orientation;
      logic [2:0]           color_op;
   } cfg_type;

   typedef struct packed {
      logic                 is_write;
      logic                 in_range;
      logic [DIM_W-1:0]     src_row;
      logic [DIM_W-1:0]     src_col;
   } map_type;

endpackage

// ===== sv/iocb_addr_map.sv =====
// Coordinate mapping: clamps sizes, checks bounds and maps output to source coordinates.
module iocb_addr_map import iocb_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  req_type req,
   input  cfg_type cfg,
   output map_type map
);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   logic [DIM_W-1:0] w, h, out_w, out_h, row_x, col_x;
   logic             rotated;

   always_comb begin
      w       = clamp_dim(cfg.image_width);
      h       = clamp_dim(cfg.image_height);
      row_x   = {1'b0, req.row};
      col_x   = {1'b0, req.col};
      rotated = (cfg.orientation == ORIENT_ROT_L) || (cfg.orientation == ORIENT_ROT_R);
      out_h   = rotated ? w : h;
      out_w   = rotated ? h : w;

      map.is_write = (req.func == FUNC_WRITE);
      map.src_row  = row_x;
      map.src_col  = col_x;
      if (map.is_write) begin
         map.in_range = (row_x < h) && (col_x < w);
      end else begin
         map.in_range = (row_x < out_h) && (col_x < out_w);
         case (cfg.orientation)
            ORIENT_FLIP_H: map.src_col = w - DIM_W'(1) - col_x;
            ORIENT_FLIP_V: map.src_row = h - DIM_W'(1) - row_x;
            ORIENT_ROT_L: begin
               map.src_row = h - DIM_W'(1) - col_x;
               map.src_col = row_x;
            end
            ORIENT_ROT_R: begin
               map.src_row = col_x;
               map.src_col = w - DIM_W'(1) - row_x;
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== sv/iocb_pixel_mem.sv =====
// Pixel store: single-port synchronous memory, registered read data.
module iocb_pixel_mem import iocb_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [DIM_W-1:0]     src_row,
   input  logic [DIM_W-1:0]     src_col,
   input  logic [PIX_W-1:0]     wr_data,
   output logic [PIX_W-1:0]     rd_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic [PIX_W-1:0] mem [0:DEPTH-1];
   logic [AW-1:0]    addr;

   // row-major, constant row pitch
   assign addr = AW'(int'(src_row) * MAX_DIM + int'(src_col));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

// ===== sv/iocb_color.sv =====
// Color stage: grey average or byte clear, error forcing, registered result.
module iocb_color import iocb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pix_valid,
   input  logic             pix_err,
   input  logic [PIX_W-1:0] pix,
   input  logic [2:0]       color_op,
   output logic             rsp_valid,
   output rsp_type          rsp
);

   logic [BYTE_W-1:0] b0, b1, b2, grey;
   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   rsp_type           rsp_in, rsp_ff;
   logic              valid_ff;

   always_comb begin
      b0   = pix[BYTE_W-1:0];
      b1   = pix[2*BYTE_W-1:BYTE_W];
      b2   = pix[3*BYTE_W-1:2*BYTE_W];
      sum  = SUM_W'(b0) + SUM_W'(b1) + SUM_W'(b2);
      prod = PROD_W'(sum) * PROD_W'(GREY_RECIP);
      grey = prod[GREY_SHIFT +: BYTE_W];
      case (color_op)
         COLOR_GREY: begin
            b0 = grey;
            b1 = grey;
            b2 = grey;
         end
         COLOR_CLEAR_2: b2 = '0;
         COLOR_CLEAR_1: b1 = '0;
         COLOR_CLEAR_0: b0 = '0;
         default: ;
      endcase
      if (pix_err) begin
         rsp_in = '{out_byte_zero: '0, out_byte_one: '0, out_byte_two: '0, status: 1'b1};
      end else begin
         rsp_in = '{out_byte_zero: b0, out_byte_one: b1, out_byte_two: b2, status: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pix_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sv/image_orient_color_buffer.sv =====
// Top level: frame buffer with orientation mapping and color operation.
// Pipeline: a read transaction passes the captured request register, the memory read register
//   and the color result register, in that order, before rsp_strobe marks its result.
// Throughput: one transaction per cycle, write or read; busy never rises. The rate is set
//   by the single pixel memory port, which serves at most one access per transaction.
// Reset clears config (width 256, height 256, identity, no color op) and pipeline valids;
//   the pixel store is not cleared and unwritten pixels read undefined.
module image_orient_color_buffer import iocb_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  req_type           req,
   // result channel
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   // config channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  csr_index_type     csr_index,
   input  logic [DIM_W-1:0]  csr_wdata
);

   // ---------------- config registers ----------------
   cfg_type cfg_ff, cfg_in;

   // config writes always accepted; the user must issue them only while idle, not enforced here
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            CSR_ORIENTATION:  cfg_in.orientation  = csr_wdata[2:0];
            CSR_COLOR_OP:     cfg_in.color_op     = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width: DIM_W'(256), image_height: DIM_W'(256),
                     orientation: ORIENT_IDENTITY, color_op: COLOR_NONE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- stage 1: captured transaction ----------------
   // Every transaction that uses the memory takes it in the same stage, in order, so a read
   // always sees all earlier writes and no forwarding is needed.
   logic    accept;
   logic    v1_ff;
   req_type req_ff;
   map_type map;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      if (accept) begin
         req_ff <= req;
      end
   end

   iocb_addr_map #(.MAX_DIM(MAX_DIM)) u_map (
      .req (req_ff),
      .cfg (cfg_ff),
      .map (map)
   );

   // ---------------- stage 2: memory access ----------------
   logic             wr_en, rd_en;
   logic             v2_ff, err2_ff;
   logic [PIX_W-1:0] rd_data;

   // out-of-range writes dropped; out-of-range reads skip the memory
   assign wr_en = v1_ff && map.is_write && map.in_range;
   assign rd_en = v1_ff && !map.is_write && map.in_range;

   iocb_pixel_mem #(.MAX_DIM(MAX_DIM)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .src_row (map.src_row),
      .src_col (map.src_col),
      .wr_data ({req_ff.byte_two, req_ff.byte_one, req_ff.byte_zero}),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff && !map.is_write;
      end
      err2_ff <= !map.in_range;
   end

   // ---------------- stage 3: color op and result register ----------------
   iocb_color u_color (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (v2_ff),
      .pix_err   (err2_ff),
      .pix       (rd_data),
      .color_op  (cfg_ff.color_op),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp_data)
   );

   // ---------------- assertions ----------------
   // each result traces back to an accepted read transaction
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req.func == FUNC_READ, 3))
      else $error("result without matching read transaction");

   // single port: never read and write in the same cycle
   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("memory read and write in same cycle");

   // error results carry zero pixel bytes
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status) |->
         (rsp_data.out_byte_zero == '0 && rsp_data.out_byte_one == '0 &&
          rsp_data.out_byte_two == '0))
      else $error("error result with nonzero bytes");

   // an in-range read issues a memory read before its result
   a_read_issued: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !err2_ff) |-> $past(rd_en))
      else $error("in-range read without memory access");

endmodule
